// ===== rtl/tds_pkg.sv =====
// Shared types and constants of the tick-driven task scheduler.
package tds_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int PID_W = 16;
  localparam int SLOT_OUT_W = 6;

  localparam logic [2:0] KIND_TICK = 3'd0;
  localparam logic [2:0] KIND_CREATE = 3'd1;
  localparam logic [2:0] KIND_DESTROY = 3'd2;
  localparam logic [2:0] KIND_STOP = 3'd3;
  localparam logic [2:0] KIND_START = 3'd4;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_NOPID = 2'd3;

  localparam logic [1:0] PH_READY = 2'd0;
  localparam logic [1:0] PH_RUNNING = 2'd1;
  localparam logic [1:0] PH_WAITING = 2'd2;
  localparam logic [1:0] PH_TERMINATED = 2'd3;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [1:0]       phase;
    logic [15:0]      period;
    logic [31:0]      stamp;
  } slot_ent_t;

endpackage

// ===== rtl/tds_if.sv =====
// Valid/ready channel interfaces for command items and result items.
interface tds_in_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                kind;
  logic [tds_pkg::PID_W-1:0] target_pid;
  logic [15:0]               wake_interval;
  modport source (output valid, kind, target_pid, wake_interval, input ready);
  modport sink (input valid, kind, target_pid, wake_interval, output ready);
endinterface

interface tds_out_if;
  logic                           valid;
  logic                           ready;
  logic [tds_pkg::PID_W-1:0]      running_pid;
  logic [tds_pkg::SLOT_OUT_W-1:0] running_slot;
  logic                           switch_request;
  logic [1:0]                     status;
  modport source (output valid, running_pid, running_slot, switch_request, status,
                  input ready);
  modport sink (input valid, running_pid, running_slot, switch_request, status,
                output ready);
endinterface

// ===== rtl/tick_driven_task_scheduler_unit.sv =====
// Task scheduler top level: slot table memory, ready ring memory and sequencer.
//
//   channel   direction  contents
//   in_ch     sink       kind, target_pid, wake_interval
//   out_ch    source     running_pid, running_slot, switch_request, status
//
// One item at a time; the slot table is walked entry by entry (read, then
// modify and write back).
// Reset is synchronous; per-slot valid bits make the table read as free at once.
// A result waits in an output register, and a new item is taken meanwhile.
module tick_driven_task_scheduler_unit #(
  parameter int NUM_SLOTS = tds_pkg::NUM_SLOTS_DEF
) (
  input logic clk,
  input logic rst_n,
  tds_in_if.sink in_ch,
  tds_out_if.source out_ch
);
  import tds_pkg::*;

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_SCAN_RD  = 12'b000000000010,
    S_SCAN_EX  = 12'b000000000100,
    S_SCAN_END = 12'b000000001000,
    S_POP_RD   = 12'b000000010000,
    S_POP_SLOT = 12'b000000100000,
    S_POP_EX   = 12'b000001000000,
    S_OLD      = 12'b000010000000,
    S_NEW      = 12'b000100000000,
    S_CREATE   = 12'b001000000000,
    S_FIN      = 12'b010000000000,
    S_OUT      = 12'b100000000000
  } state_t;

  typedef enum logic [1:0] {
    M_WAKE  = 2'd0,
    M_FREE  = 2'd1,
    M_MATCH = 2'd2,
    M_FINAL = 2'd3
  } mode_t;

  slot_ent_t slot_mem [NUM_SLOTS];
  logic [IW-1:0] ring_mem [NUM_SLOTS];

  state_t state_r, state_nxt;
  mode_t mode_r, mode_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [PID_W-1:0] key_r, key_nxt;
  logic found_r, found_nxt;
  logic [IW-1:0] mslot_r, mslot_nxt;
  slot_ent_t mdata_r, mdata_nxt;
  logic [IW-1:0] nslot_r, nslot_nxt;
  slot_ent_t nent_r, nent_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic [15:0] wint_r, wint_nxt;
  logic [NUM_SLOTS-1:0] vld_r, vld_nxt;
  logic [IW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [PID_W-1:0] pid_src_r, pid_src_nxt, cur_pid_r, cur_pid_nxt;
  logic sw_r, sw_nxt;
  logic [1:0] stat_r, stat_nxt;
  logic [PID_W-1:0] res_pid_r, res_pid_nxt;
  logic [SLOT_OUT_W-1:0] res_slot_r, res_slot_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [PID_W-1:0] o_pid_r, o_pid_nxt;
  logic [SLOT_OUT_W-1:0] o_slot_r, o_slot_nxt;
  logic o_sw_r, o_sw_nxt;
  logic [1:0] o_stat_r, o_stat_nxt;

  logic [IW-1:0] raddr;
  slot_ent_t rdata_r;
  logic rvld_r;
  logic [IW-1:0] ring_rd_r;
  logic s_we;
  logic [IW-1:0] s_waddr;
  slot_ent_t s_wdata;
  logic push_req;
  logic [IW-1:0] push_idx;
  logic ring_we;
  slot_ent_t ent;
  slot_ent_t wk;
  logic is_match;
  logic due;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] p);
    ring_next = (p == IW'(NUM_SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    rdata_r <= slot_mem[raddr];
    rvld_r <= vld_r[raddr];
    ring_rd_r <= ring_mem[head_r];
    if (s_we) begin
      slot_mem[s_waddr] <= s_wdata;
    end
    if (ring_we) begin
      ring_mem[tail_r] <= push_idx;
    end
  end

  always_comb begin
    ent = rdata_r;
    if (!rvld_r) begin
      ent.pid = '0;
      ent.phase = PH_READY;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt = mode_r;
    idx_nxt = idx_r;
    key_nxt = key_r;
    found_nxt = found_r;
    mslot_nxt = mslot_r;
    mdata_nxt = mdata_r;
    nslot_nxt = nslot_r;
    nent_nxt = nent_r;
    kind_nxt = kind_r;
    wint_nxt = wint_r;
    vld_nxt = vld_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt = cnt_r;
    tick_nxt = tick_r;
    pid_src_nxt = pid_src_r;
    cur_pid_nxt = cur_pid_r;
    sw_nxt = sw_r;
    stat_nxt = stat_r;
    res_pid_nxt = res_pid_r;
    res_slot_nxt = res_slot_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    o_pid_nxt = o_pid_r;
    o_slot_nxt = o_slot_r;
    o_sw_nxt = o_sw_r;
    o_stat_nxt = o_stat_r;
    raddr = idx_r;
    s_we = 1'b0;
    s_waddr = idx_r;
    s_wdata = ent;
    push_req = 1'b0;
    push_idx = idx_r;
    ring_we = 1'b0;
    wk = ent;
    is_match = 1'b0;
    due = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt = in_ch.kind;
          wint_nxt = in_ch.wake_interval;
          sw_nxt = 1'b0;
          stat_nxt = STAT_OK;
          idx_nxt = '0;
          found_nxt = 1'b0;
          state_nxt = S_SCAN_RD;
          case (in_ch.kind)
            KIND_TICK: begin
              mode_nxt = M_WAKE;
              key_nxt = cur_pid_r;
            end
            KIND_CREATE: begin
              mode_nxt = M_FREE;
              key_nxt = '0;
              pid_src_nxt = (pid_src_r == {PID_W{1'b1}}) ? PID_W'(1) : pid_src_r + 1'b1;
            end
            KIND_DESTROY: begin
              mode_nxt = M_MATCH;
              key_nxt = in_ch.target_pid;
            end
            KIND_STOP: begin
              mode_nxt = M_MATCH;
              key_nxt = cur_pid_r;
            end
            KIND_START: begin
              state_nxt = S_POP_RD;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_EX;
      end
      S_SCAN_EX: begin
        due = ({1'b0, ent.stamp} + {17'b0, ent.period}) <= {1'b0, tick_r};
        if (mode_r == M_WAKE && ent.pid != '0 && ent.phase == PH_WAITING && due) begin
          wk.phase = PH_READY;
          s_we = 1'b1;
          s_wdata = wk;
          push_req = 1'b1;
        end
        if (mode_r == M_FREE) begin
          is_match = (ent.pid == '0);
        end else begin
          is_match = (key_r != '0) && (ent.pid == key_r);
        end
        if (is_match && !found_r) begin
          found_nxt = 1'b1;
          mslot_nxt = idx_r;
          mdata_nxt = wk;
        end
        if (idx_r == IW'(NUM_SLOTS - 1)) begin
          state_nxt = S_SCAN_END;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_END: begin
        case (mode_r)
          M_WAKE: begin
            tick_nxt = tick_r + 1'b1;
            state_nxt = S_POP_RD;
          end
          M_FREE: begin
            if (found_r) begin
              state_nxt = S_CREATE;
            end else begin
              res_pid_nxt = '0;
              res_slot_nxt = '0;
              stat_nxt = STAT_FULL;
              state_nxt = S_OUT;
            end
          end
          M_MATCH: begin
            state_nxt = S_FIN;
            if (!found_r) begin
              stat_nxt = STAT_NOPID;
            end else if (kind_r == KIND_DESTROY) begin
              vld_nxt[mslot_r] = 1'b0;
            end else begin
              s_we = 1'b1;
              s_waddr = mslot_r;
              s_wdata = mdata_r;
              s_wdata.phase = PH_TERMINATED;
            end
          end
          default: begin
            res_pid_nxt = cur_pid_r;
            res_slot_nxt = found_r ? SLOT_OUT_W'(mslot_r) : '0;
            state_nxt = S_OUT;
          end
        endcase
      end
      S_POP_RD: begin
        if (cnt_r == '0) begin
          stat_nxt = STAT_EMPTY;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_POP_SLOT;
        end
      end
      S_POP_SLOT: begin
        raddr = ring_rd_r;
        nslot_nxt = ring_rd_r;
        head_nxt = ring_next(head_r);
        cnt_nxt = cnt_r - 1'b1;
        state_nxt = S_POP_EX;
      end
      S_POP_EX: begin
        nent_nxt = ent;
        if (ent.pid == '0) begin
          stat_nxt = STAT_EMPTY;
          state_nxt = S_FIN;
        end else if (kind_r == KIND_TICK && found_r) begin
          state_nxt = (nslot_r == mslot_r) ? S_FIN : S_OLD;
        end else begin
          state_nxt = S_NEW;
        end
      end
      S_OLD: begin
        s_waddr = mslot_r;
        s_wdata = mdata_r;
        push_idx = mslot_r;
        if (mdata_r.phase == PH_RUNNING) begin
          s_we = 1'b1;
          if (mdata_r.period != '0) begin
            s_wdata.phase = PH_WAITING;
            s_wdata.stamp = tick_r;
          end else begin
            s_wdata.phase = PH_READY;
            push_req = 1'b1;
          end
        end else if (mdata_r.phase == PH_TERMINATED) begin
          vld_nxt[mslot_r] = 1'b0;
        end
        state_nxt = S_NEW;
      end
      S_NEW: begin
        s_we = 1'b1;
        s_waddr = nslot_r;
        s_wdata = nent_r;
        s_wdata.phase = PH_RUNNING;
        cur_pid_nxt = nent_r.pid;
        sw_nxt = 1'b1;
        state_nxt = S_FIN;
      end
      S_CREATE: begin
        s_we = 1'b1;
        s_waddr = mslot_r;
        s_wdata.pid = pid_src_r;
        s_wdata.phase = PH_READY;
        s_wdata.period = wint_r;
        s_wdata.stamp = tick_r;
        vld_nxt[mslot_r] = 1'b1;
        push_req = 1'b1;
        push_idx = mslot_r;
        res_pid_nxt = pid_src_r;
        res_slot_nxt = SLOT_OUT_W'(mslot_r);
        state_nxt = S_OUT;
      end
      S_FIN: begin
        mode_nxt = M_FINAL;
        key_nxt = cur_pid_r;
        idx_nxt = '0;
        found_nxt = 1'b0;
        state_nxt = S_SCAN_RD;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_pid_nxt = res_pid_r;
          o_slot_nxt = res_slot_r;
          o_sw_nxt = sw_r;
          o_stat_nxt = stat_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (push_req && cnt_r < CW'(NUM_SLOTS)) begin
      ring_we = 1'b1;
      tail_nxt = ring_next(tail_r);
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      cnt_r <= '0;
      tick_r <= '0;
      pid_src_r <= '0;
      cur_pid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r <= vld_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r <= cnt_nxt;
      tick_r <= tick_nxt;
      pid_src_r <= pid_src_nxt;
      cur_pid_r <= cur_pid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    idx_r <= idx_nxt;
    key_r <= key_nxt;
    found_r <= found_nxt;
    mslot_r <= mslot_nxt;
    mdata_r <= mdata_nxt;
    nslot_r <= nslot_nxt;
    nent_r <= nent_nxt;
    kind_r <= kind_nxt;
    wint_r <= wint_nxt;
    sw_r <= sw_nxt;
    stat_r <= stat_nxt;
    res_pid_r <= res_pid_nxt;
    res_slot_r <= res_slot_nxt;
    o_pid_r <= o_pid_nxt;
    o_slot_r <= o_slot_nxt;
    o_sw_r <= o_sw_nxt;
    o_stat_r <= o_stat_nxt;
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.running_pid = o_pid_r;
  assign out_ch.running_slot = o_slot_r;
  assign out_ch.switch_request = o_sw_r;
  assign out_ch.status = o_stat_r;

endmodule

// ===== bench/tb_tick_driven_task_scheduler_unit.sv =====
// Testbench for the task scheduler: a scoreboard predicts every result item and checks it.
module tb_tick_driven_task_scheduler_unit;
  import tds_pkg::*;

  localparam int SLOTS = NUM_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1500;

  typedef struct packed {
    logic [PID_W-1:0]      pid;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  sw;
    logic [1:0]            status;
  } sched_result_t;

  class sched_scoreboard;
    logic [PID_W-1:0] pid_of[SLOTS];
    logic [1:0]       phase_of[SLOTS];
    logic [15:0]      period_of[SLOTS];
    logic [31:0]      stamp_of[SLOTS];
    int               ring[SLOTS];
    int               head, tail, count;
    logic [31:0]      ticks;
    logic [PID_W-1:0] next_pid;
    logic [PID_W-1:0] running;
    sched_result_t    expected_results[$];
    int               errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        pid_of[i] = '0;
        phase_of[i] = PH_READY;
        ring[i] = 0;
      end
      head = 0;
      tail = 0;
      count = 0;
      ticks = '0;
      next_pid = '0;
      running = '0;
      errors = 0;
    endfunction

    function void push_slot(int s);
      if (count >= SLOTS) return;
      ring[tail] = s;
      tail = (tail + 1) % SLOTS;
      count++;
    endfunction

    function int pop_slot();
      int s;
      if (count == 0) return -1;
      s = ring[head];
      head = (head + 1) % SLOTS;
      count--;
      if (pid_of[s] == '0) return -1;
      return s;
    endfunction

    function int slot_with_pid(logic [PID_W-1:0] p);
      if (p == '0) return -1;
      for (int i = 0; i < SLOTS; i++)
        if (pid_of[i] == p) return i;
      return -1;
    endfunction

    function void note_command(logic [2:0] kind, logic [15:0] tpid, logic [15:0] wint);
      sched_result_t r;
      int cur, nxt, idx;
      r = '0;
      case (kind)
        KIND_TICK: begin
          for (int i = 0; i < SLOTS; i++)
            if (pid_of[i] != '0 && phase_of[i] == PH_WAITING &&
                ({1'b0, stamp_of[i]} + {17'b0, period_of[i]}) <= {1'b0, ticks}) begin
              phase_of[i] = PH_READY;
              push_slot(i);
            end
          ticks = ticks + 32'd1;
          cur = slot_with_pid(running);
          nxt = pop_slot();
          if (nxt < 0) begin
            r.status = STAT_EMPTY;
          end else if (nxt != cur) begin
            if (cur >= 0) begin
              if (phase_of[cur] == PH_RUNNING) begin
                if (period_of[cur] > 0) begin
                  phase_of[cur] = PH_WAITING;
                  stamp_of[cur] = ticks;
                end else begin
                  phase_of[cur] = PH_READY;
                  push_slot(cur);
                end
              end else if (phase_of[cur] == PH_TERMINATED) begin
                pid_of[cur] = '0;
              end
            end
            phase_of[nxt] = PH_RUNNING;
            running = pid_of[nxt];
            r.sw = 1'b1;
          end
        end
        KIND_CREATE: begin
          next_pid = next_pid + 1'b1;
          if (next_pid == '0) next_pid = PID_W'(1);
          idx = -1;
          for (int i = SLOTS - 1; i >= 0; i--)
            if (pid_of[i] == '0) idx = i;
          if (idx < 0) begin
            r.status = STAT_FULL;
          end else begin
            pid_of[idx] = next_pid;
            period_of[idx] = wint;
            stamp_of[idx] = ticks;
            phase_of[idx] = PH_READY;
            push_slot(idx);
            r.pid = next_pid;
            r.slot = SLOT_OUT_W'(idx);
          end
          expected_results.push_back(r);
          return;
        end
        KIND_DESTROY: begin
          idx = slot_with_pid(tpid);
          if (idx < 0) r.status = STAT_NOPID;
          else pid_of[idx] = '0;
        end
        KIND_STOP: begin
          cur = slot_with_pid(running);
          if (cur < 0) r.status = STAT_NOPID;
          else phase_of[cur] = PH_TERMINATED;
        end
        KIND_START: begin
          nxt = pop_slot();
          if (nxt < 0) begin
            r.status = STAT_EMPTY;
          end else begin
            phase_of[nxt] = PH_RUNNING;
            running = pid_of[nxt];
            r.sw = 1'b1;
          end
        end
        default: ;
      endcase
      r.pid = running;
      idx = slot_with_pid(running);
      r.slot = (idx < 0) ? '0 : SLOT_OUT_W'(idx);
      expected_results.push_back(r);
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t exp;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result pid=%0d slot=%0d sw=%0d status=%0d", $time,
                 got.pid, got.slot, got.sw, got.status);
        errors++;
        return;
      end
      exp = expected_results.pop_front();
      if (got.pid !== exp.pid) begin
        $display("%0t: running_pid expected %0d actual %0d", $time, exp.pid, got.pid);
        errors++;
      end
      if (got.slot !== exp.slot) begin
        $display("%0t: running_slot expected %0d actual %0d", $time, exp.slot, got.slot);
        errors++;
      end
      if (got.sw !== exp.sw) begin
        $display("%0t: switch_request expected %0d actual %0d", $time, exp.sw, got.sw);
        errors++;
      end
      if (got.status !== exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  tds_in_if in_ch();
  tds_out_if out_ch();
  sched_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int cycles = 0;

  tick_driven_task_scheduler_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #1 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.target_pid = '0;
    in_ch.wake_interval = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tick_driven_task_scheduler_unit: mismatch");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.running_pid, out_ch.running_slot, out_ch.switch_request,
                       out_ch.status});
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(logic [2:0] kind, logic [15:0] tpid, logic [15:0] wint);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.target_pid <= tpid;
    in_ch.wake_interval <= wint;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(kind, tpid, wint);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_item();
    int pick;
    logic [15:0] tpid;
    logic [15:0] wint;
    pick = $urandom_range(99);
    tpid = 16'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: wint = '0;
      5, 6, 7, 8: wint = 16'($urandom_range(1, 6));
      default: wint = 16'($urandom);
    endcase
    if (pick < 40) begin
      send_item(KIND_TICK, tpid, wint);
    end else if (pick < 60) begin
      send_item(KIND_CREATE, tpid, wint);
    end else if (pick < 75) begin
      if ($urandom_range(3) != 0) tpid = sb.pid_of[$urandom_range(SLOTS - 1)];
      send_item(KIND_DESTROY, tpid, wint);
    end else if (pick < 84) begin
      send_item(KIND_STOP, tpid, wint);
    end else if (pick < 97) begin
      send_item(KIND_START, tpid, wint);
    end else begin
      send_item(3'($urandom_range(5, 7)), tpid, wint);
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(KIND_TICK, 16'hffff, 16'hffff);
    send_item(KIND_START, 16'h0000, 16'h0000);
    send_item(KIND_STOP, 16'h0000, 16'h0000);
    send_item(KIND_DESTROY, 16'h0000, 16'h0000);
    send_item(KIND_DESTROY, 16'hffff, 16'h0000);
    send_item(KIND_CREATE, 16'h0000, 16'h0000);
    send_item(KIND_CREATE, 16'h0000, 16'hffff);
    send_item(KIND_CREATE, 16'h0000, 16'h0001);
    for (int i = 0; i < SLOTS - 3; i++) send_item(KIND_CREATE, 16'h0000, 16'h0002);
    send_item(KIND_CREATE, 16'h0000, 16'h0000);
    send_item(KIND_START, 16'h0000, 16'h0000);
    send_item(KIND_TICK, 16'h0000, 16'h0000);
    send_item(KIND_TICK, 16'h0000, 16'h0000);
    send_item(KIND_STOP, 16'h0000, 16'h0000);
    send_item(KIND_TICK, 16'h0000, 16'h0000);
    send_item(KIND_DESTROY, sb.running, 16'h0000);
    send_item(KIND_TICK, 16'h0000, 16'h0000);
    send_item(3'd5, 16'h5555, 16'haaaa);
    send_item(3'd6, 16'haaaa, 16'h5555);
    send_item(3'd7, 16'hffff, 16'hffff);
    send_item(KIND_TICK, 16'h0000, 16'h0000);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = (p == 1) ? 60 : (p == 3) ? 20 : 0;
      recv_stall_pct = (p == 2) ? 60 : (p == 3) ? 20 : 0;
      if (p == 1) hold_request = 400;
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) send_random_item();
      if (p == 2) wait_for_results();
    end

    wait_for_results();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0)
      $display("tick_driven_task_scheduler_unit: match");
    else
      $display("tick_driven_task_scheduler_unit: mismatch");
    $finish;
  end
endmodule
